// File: sv/tcgr_pkg.sv
// tcgr_pkg: shared types and constants of the text console glyph renderer
// no dependencies; used by text_console_glyph_renderer, tcgr_checker and the testbench
`default_nettype none

package tcgr_pkg;

	localparam int GLYPH_WIDTH     = 8;
	localparam int FIRST_PRINTABLE = 32;
	localparam int NEWLINE_CODE    = 10;
	localparam int COL_LIMIT_MAX   = 512;
	localparam int ROW_LIMIT_MAX   = 256;

	localparam int FB_WIDTH_W  = 13;
	localparam int COLUMNS_W   = 10;
	localparam int ROWS_W      = 9;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int PIX_INDEX_W = 24;
	localparam int FONT_IDX_W  = 12;
	localparam int ROW_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FB_WIDTH     = 2'd0,
		CFG_TEXT_COLUMNS = 2'd1,
		CFG_TEXT_ROWS    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD_ROW = 1'b0,
		OP_PUT_CHAR = 1'b1
	} op_t;

	typedef struct packed {
		logic                  op;
		logic [7:0]            char_code;
		logic [FONT_IDX_W-1:0] font_row_index;
		logic [ROW_DATA_W-1:0] font_row_data;
	} cmd_t;

	typedef struct packed {
		logic [PIX_INDEX_W-1:0] pixel_index;
		logic [ROW_DATA_W-1:0]  row_pixels;
		logic                   last;
	} pix_t;

endpackage

`default_nettype wire

// File: sv/tcgr_ram.sv
// tcgr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tcgr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 3584,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/text_console_glyph_renderer.sv
// text_console_glyph_renderer: cursor tracking and glyph row streaming top level
// depends on tcgr_pkg and tcgr_ram
`default_nettype none

// A load command writes one 64-bit glyph row into the font RAM and leaves the
// command channel free, as do newlines and ignored codes. A printable character
// first captures the cursor, then does the row-start multiply, then makes one
// font RAM read per glyph row; these reads are the limit on throughput and wait
// while the output is stalled. Results leave through an output register, so the
// last rows drain while the next command is already accepted. The font RAM is not
// cleared at reset; glyph rows must be loaded before they are drawn.
module text_console_glyph_renderer #(
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 224,
	parameter int MAX_FB_WIDTH = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_stall,
	input  wire tcgr_pkg::cmd_t                  cmd,
	output logic                                 pix_valid,
	input  wire logic                            pix_stall,
	output tcgr_pkg::pix_t                       pix,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import tcgr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(GLYPH_HEIGHT);
	localparam int YW = 8 + $clog2(GLYPH_HEIGHT);
	localparam int PW = YW + FB_WIDTH_W;
	localparam int XW = 12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_RUN
	} state_t;

	state_t                  state_q;
	logic [FB_WIDTH_W-1:0]   fb_width_q;
	logic [COLUMNS_W-1:0]    text_columns_q;
	logic [ROWS_W-1:0]       text_rows_q;
	logic [8:0]              cursor_col_q;
	logic [7:0]              cursor_row_q;

	logic [YW-1:0]           y0_q;
	logic [XW-1:0]           x_q;
	logic [FB_WIDTH_W-1:0]   stride_q;
	logic [AW-1:0]           addr_q;
	logic [CW-1:0]           row_cnt_q;
	logic [PIX_INDEX_W-1:0]  idx_q;

	logic                    vld_s1;
	logic [PIX_INDEX_W-1:0]  idx_s1;
	logic                    last_s1;

	logic                    pix_valid_q;
	pix_t                    pix_q;

	logic                    cmd_acc;
	logic                    cfg_acc;
	logic                    glyph_ok;
	logic [8:0]              code_off;
	logic [9:0]              ncol;
	logic [COLUMNS_W-1:0]    col_limit;
	logic [8:0]              nrow;
	logic [ROWS_W-1:0]       row_limit;
	logic [7:0]              row_next;
	logic                    col_wrap;
	logic [FB_WIDTH_W-1:0]   stride;
	logic [PW-1:0]           prod;
	logic                    out_free;
	logic                    rd_en;
	logic                    last_row;
	logic                    font_we;
	logic [ROW_DATA_W-1:0]   font_rdata;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	always_comb begin
		cmd_acc   = cmd_valid && !cmd_stall;
		cfg_acc   = cfg_valid && cfg_ready;
		code_off  = 9'(cmd.char_code) - 9'(FIRST_PRINTABLE);
		glyph_ok  = (cmd.char_code >= 8'(FIRST_PRINTABLE)) && (code_off < 9'(GLYPH_COUNT));
		font_we   = cmd_acc && (cmd.op == OP_LOAD_ROW)
		            && ({1'b0, cmd.font_row_index} < 13'(STORE_DEPTH));

		// a zero limit wraps on every step, same as a limit of one
		col_limit = (text_columns_q > 10'(COL_LIMIT_MAX)) ? 10'(COL_LIMIT_MAX) : text_columns_q;
		row_limit = (text_rows_q > 9'(ROW_LIMIT_MAX)) ? 9'(ROW_LIMIT_MAX) : text_rows_q;
		ncol      = 10'(cursor_col_q) + 10'd1;
		nrow      = 9'(cursor_row_q) + 9'd1;
		col_wrap  = (ncol >= col_limit);
		row_next  = (nrow >= row_limit) ? 8'd0 : nrow[7:0];

		stride    = (14'(fb_width_q) > 14'(MAX_FB_WIDTH)) ? FB_WIDTH_W'(MAX_FB_WIDTH) : fb_width_q;
		prod      = PW'(y0_q) * PW'(stride_q);

		out_free  = !pix_valid_q || !pix_stall;
		rd_en     = (state_q == ST_RUN) && (!vld_s1 || out_free);
		last_row  = (row_cnt_q == CW'(GLYPH_HEIGHT - 1));
	end

	tcgr_ram #(
		.WIDTH (ROW_DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (AW'(cmd.font_row_index)),
		.wdata (cmd.font_row_data),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (font_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fb_width_q     <= 13'd1024;
			text_columns_q <= 10'd128;
			text_rows_q    <= 9'd48;
			cursor_col_q   <= '0;
			cursor_row_q   <= '0;
			y0_q           <= '0;
			x_q            <= '0;
			stride_q       <= '0;
			addr_q         <= '0;
			row_cnt_q      <= '0;
			idx_q          <= '0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			last_s1        <= 1'b0;
			pix_valid_q    <= 1'b0;
			pix_q          <= '0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					CFG_FB_WIDTH:     fb_width_q     <= cfg_data;
					CFG_TEXT_COLUMNS: text_columns_q <= cfg_data[COLUMNS_W-1:0];
					CFG_TEXT_ROWS:    text_rows_q    <= cfg_data[ROWS_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.op == OP_PUT_CHAR) begin
						if (cmd.char_code == 8'(NEWLINE_CODE)) begin
							cursor_col_q <= '0;
							cursor_row_q <= row_next;
						end else if (glyph_ok) begin
							y0_q     <= YW'(cursor_row_q) * YW'(GLYPH_HEIGHT);
							x_q      <= XW'(cursor_col_q) * XW'(GLYPH_WIDTH);
							stride_q <= stride;
							addr_q   <= AW'(code_off) * AW'(GLYPH_HEIGHT);
							if (col_wrap) begin
								cursor_col_q <= '0;
								cursor_row_q <= row_next;
							end else begin
								cursor_col_q <= ncol[8:0];
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					idx_q     <= PIX_INDEX_W'(prod) + PIX_INDEX_W'(x_q);
					row_cnt_q <= '0;
					state_q   <= ST_RUN;
				end
				ST_RUN: begin
					if (rd_en) begin
						addr_q    <= addr_q + AW'(1);
						idx_q     <= idx_q + PIX_INDEX_W'(stride_q);
						row_cnt_q <= row_cnt_q + CW'(1);
						if (last_row) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// read stage: one glyph row in flight, data arrives from the ram next cycle
			if (rd_en) begin
				vld_s1  <= 1'b1;
				idx_s1  <= idx_q;
				last_s1 <= last_row;
			end else if (vld_s1 && out_free) begin
				vld_s1 <= 1'b0;
			end

			if (vld_s1 && out_free) begin
				pix_valid_q       <= 1'b1;
				pix_q.pixel_index <= idx_s1;
				pix_q.row_pixels  <= font_rdata;
				pix_q.last        <= last_s1;
			end else if (pix_valid_q && !pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/tcgr_checker.sv
// tcgr_checker: port-level assertions for the glyph renderer, bound to the top level
// depends on tcgr_pkg
`default_nettype none

module tcgr_checker #(
	parameter int GLYPH_COUNT = 224
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_stall,
	input wire tcgr_pkg::cmd_t cmd,
	input wire logic           pix_valid,
	input wire logic           pix_stall,
	input wire tcgr_pkg::pix_t pix
);

	import tcgr_pkg::*;

	logic cmd_acc;
	logic put_glyph;

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign put_glyph = (cmd.op == OP_PUT_CHAR) && (cmd.char_code >= 8'(FIRST_PRINTABLE))
	                   && ((9'(cmd.char_code) - 9'(FIRST_PRINTABLE)) < 9'(GLYPH_COUNT));

	// a stalled result transaction keeps its payload
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("result changed while stalled");

	// a drawn character blocks the command channel while its rows are read
	a_glyph_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && put_glyph |=> cmd_stall)
		else $error("command taken during glyph rendering");

	// a font row load leaves the command channel free
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.op == OP_LOAD_ROW |=> !cmd_stall)
		else $error("stall after font row load");

	// no result appears right after reset without a drawn character
	a_no_early_pix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !pix_valid)
		else $error("result valid coming out of reset");

endmodule

bind text_console_glyph_renderer tcgr_checker #(
	.GLYPH_COUNT (GLYPH_COUNT)
) u_tcgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix)
);

`default_nettype wire

// File: tb/tb_text_console_glyph_renderer.sv
// tb_text_console_glyph_renderer: self-checking bench for the glyph renderer
// loads glyphs, streams characters through several register settings and scores every row
// depends on tcgr_pkg and text_console_glyph_renderer
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer;
	import tcgr_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int GLYPH_H        = 16;
	localparam int GLYPH_N        = 224;
	localparam int MAX_FB         = 4096;
	localparam int STORE_ROWS     = GLYPH_N * GLYPH_H;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT_ROW    = 120;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_PRINTED    = 40;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_t                   cmd       = '0;
	logic                   pix_valid;
	logic                   pix_stall = 1'b1;
	pix_t                   pix;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// predicts the glyph rows of each character and scores what comes out
	class glyph_row_scoreboard;
		logic [FB_WIDTH_W-1:0] fb_width;
		logic [COLUMNS_W-1:0]  columns;
		logic [ROWS_W-1:0]     rows;
		logic [8:0]            cur_col;
		logic [7:0]            cur_row;
		logic [ROW_DATA_W-1:0] font_rows [STORE_ROWS];
		pix_t                  expected_rows [$];
		int                    errors;

		function new();
			fb_width = 13'd1024;
			columns  = 10'd128;
			rows     = 9'd48;
			cur_col  = '0;
			cur_row  = '0;
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_FB_WIDTH:     fb_width = val[FB_WIDTH_W-1:0];
				CFG_TEXT_COLUMNS: columns  = val[COLUMNS_W-1:0];
				CFG_TEXT_ROWS:    rows     = val[ROWS_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] next_row(logic [7:0] r);
			int lim;
			lim = (rows > ROW_LIMIT_MAX) ? ROW_LIMIT_MAX : int'(rows);
			return (int'(r) + 1 >= lim) ? 8'd0 : r + 8'd1;
		endfunction

		function void note_cmd(cmd_t c);
			int     code;
			int     stride;
			int     climit;
			int     base;
			longint idx_calc;
			pix_t   p;
			code = c.char_code;
			if (c.op == OP_LOAD_ROW) begin
				if (c.font_row_index < STORE_ROWS)
					font_rows[c.font_row_index] = c.font_row_data;
				return;
			end
			if (code == NEWLINE_CODE) begin
				cur_col = '0;
				cur_row = next_row(cur_row);
				return;
			end
			if (code < FIRST_PRINTABLE || code - FIRST_PRINTABLE >= GLYPH_N)
				return;
			stride = (fb_width > MAX_FB) ? MAX_FB : int'(fb_width);
			climit = (columns > COL_LIMIT_MAX) ? COL_LIMIT_MAX : int'(columns);
			base   = (code - FIRST_PRINTABLE) * GLYPH_H;
			for (int r = 0; r < GLYPH_H; r++) begin
				idx_calc = (longint'(cur_row) * GLYPH_H + r) * stride
					+ longint'(cur_col) * GLYPH_WIDTH;
				p.pixel_index = idx_calc[PIX_INDEX_W-1:0];
				p.row_pixels  = font_rows[base + r];
				p.last        = (r == GLYPH_H - 1);
				expected_rows.push_back(p);
			end
			// zero limit behaves as one since the wrap test is >=
			if (int'(cur_col) + 1 >= climit) begin
				cur_col = '0;
				cur_row = next_row(cur_row);
			end else begin
				cur_col = cur_col + 9'd1;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_row(pix_t got);
			pix_t want;
			if (expected_rows.size() == 0) begin
				report($sformatf("unexpected row, index %h data %h", got.pixel_index,
					got.row_pixels));
				return;
			end
			want = expected_rows.pop_front();
			if (got.pixel_index !== want.pixel_index)
				report($sformatf("pixel_index %h, expected %h", got.pixel_index,
					want.pixel_index));
			if (got.row_pixels !== want.row_pixels)
				report($sformatf("row_pixels %h, expected %h", got.row_pixels,
					want.row_pixels));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		endtask
	endclass

	glyph_row_scoreboard sb;
	bit                  row_written [STORE_ROWS];
	int                  ready_codes [$];
	int                  src_burst   = 0;
	int                  sink_burst  = 0;
	int                  quiet_cycles = 0;

	text_console_glyph_renderer #(
		.GLYPH_HEIGHT(GLYPH_H),
		.GLYPH_COUNT (GLYPH_N),
		.MAX_FB_WIDTH(MAX_FB)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_wait(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0)
			burst_left = $urandom_range(8, 30);
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [ROW_DATA_W-1:0] rand_row();
		return {$urandom, $urandom};
	endfunction

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = draw_wait(src_burst);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c);
	endtask

	task automatic load_row(input int idx, input logic [ROW_DATA_W-1:0] data);
		cmd_t c;
		int   g;
		bit   complete;
		c.op             = OP_LOAD_ROW;
		c.char_code      = 8'($urandom);
		c.font_row_index = FONT_IDX_W'(idx);
		c.font_row_data  = data;
		send_cmd(c);
		if (idx < STORE_ROWS && !row_written[idx]) begin
			row_written[idx] = 1'b1;
			g        = idx / GLYPH_H;
			complete = 1'b1;
			for (int r = 0; r < GLYPH_H; r++)
				complete &= row_written[g * GLYPH_H + r];
			// a glyph may only be drawn once all of its rows hold data
			if (complete)
				ready_codes.push_back(g + FIRST_PRINTABLE);
		end
	endtask

	task automatic load_glyph(input int code);
		for (int r = 0; r < GLYPH_H; r++)
			load_row((code - FIRST_PRINTABLE) * GLYPH_H + r, rand_row());
	endtask

	task automatic put_char(input int code);
		cmd_t c;
		c.op             = OP_PUT_CHAR;
		c.char_code      = 8'(code);
		c.font_row_index = FONT_IDX_W'($urandom);
		c.font_row_data  = rand_row();
		send_cmd(c);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input int fb, input int cols, input int text_lines,
		input bit poke_unused);
		write_reg(CFG_FB_WIDTH, CFG_DATA_W'(fb));
		if (poke_unused)
			write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(CFG_TEXT_COLUMNS, CFG_DATA_W'(cols));
		write_reg(CFG_TEXT_ROWS, CFG_DATA_W'(text_lines));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (sb.expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly characters from loaded glyphs, with font updates and junk mixed in
	task automatic run_mix(input int count);
		int pick;
		int code;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
			if (pick < 55)
				put_char(code);
			else if (pick < 63)
				load_row((code - FIRST_PRINTABLE) * GLYPH_H + $urandom_range(0, GLYPH_H - 1),
					rand_row());
			else if (pick < 67)
				load_glyph($urandom_range(FIRST_PRINTABLE, FIRST_PRINTABLE + GLYPH_N - 1));
			else if (pick < 75)
				put_char(NEWLINE_CODE);
			else if (pick < 85)
				put_char($urandom_range(0, FIRST_PRINTABLE - 1));
			else if (pick < 92)
				load_row($urandom_range(STORE_ROWS, (1 << FONT_IDX_W) - 1), rand_row());
			else
				load_row($urandom_range(0, STORE_ROWS - 1), rand_row());
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset settings
		load_glyph(FIRST_PRINTABLE);
		load_glyph(FIRST_PRINTABLE + GLYPH_N - 1);
		load_row(0, '0);
		load_row(GLYPH_H - 1, '1);
		put_char(FIRST_PRINTABLE);
		put_char(FIRST_PRINTABLE + GLYPH_N - 1);
		put_char(NEWLINE_CODE);
		put_char(0);
		put_char(FIRST_PRINTABLE - 1);
		load_row((1 << FONT_IDX_W) - 1, rand_row());
		load_row(STORE_ROWS, rand_row());
		put_char(FIRST_PRINTABLE + GLYPH_N - 1);
		put_char(NEWLINE_CODE);
		put_char(FIRST_PRINTABLE);
		wait_idle();

		configure(MAX_FB, COL_LIMIT_MAX, ROW_LIMIT_MAX, 1'b0);
		run_mix(10);
		wait_idle();
		// cursor is now past the narrow limit and has to wrap
		configure(8, 3, 2, 1'b0);
		run_mix(9);
		wait_idle();
		configure((1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1, 1'b0);
		run_mix(9);
		wait_idle();
		configure(0, 0, 0, 1'b0);
		run_mix(8);
		wait_idle();
		configure($urandom_range(8, MAX_FB), $urandom_range(1, COL_LIMIT_MAX),
			$urandom_range(1, ROW_LIMIT_MAX), 1'b1);
		run_mix(10);
		wait_idle();
		configure(640, 1, 1, 1'b1);
		run_mix(8);
		wait_idle();

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : pixel_sink
		int  n;
		int  rows_seen;
		bit  held;
		rows_seen = 0;
		held      = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = draw_wait(sink_burst);
			if (n > 0) begin
				pix_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			pix_stall <= 1'b0;
			do @(posedge clk); while (!pix_valid);
			sb.check_row(pix);
			rows_seen++;
			// long hold-off while commands keep coming, so the input backs up
			if (!held && rows_seen >= HOLD_AT_ROW && cmd_valid) begin
				held = 1'b1;
				pix_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
